[rtl/core/stable_merge_sorter_core_defines.svh]
// Assertion macros for the stable merge sorter core
`ifndef STABLE_MERGE_SORTER_CORE_DEFINES_SVH
`define STABLE_MERGE_SORTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define SMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter check failed");
`define SMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter check failed");
`else
`define SMS_ASSERT_NOW(lbl, ante, cons)
`define SMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/sms_pkg.sv]
// Shared constants and types of the stable merge sorter
`timescale 1ns / 1ps
`default_nettype none
package sms_pkg;
	localparam int DEPTH      = 32;
	localparam int DATA_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = CNT_W + 2;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam data_t SIGN_MASK = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic  en;
		idx_t  addr;
		data_t data;
	} ram_wr_t;

	typedef struct packed {
		idx_t addr_a;
		idx_t addr_b;
	} ram_rd_t;
endpackage
`default_nettype wire

[rtl/core/stable_merge_sorter_core.sv]
// Top level of the stable merge sorter: load, bottom-up merge passes, drain
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, value, last          | into core
//  out     | out_valid, out_ready, sorted_value,       | out of core
//          | sorted_last                              |
//
// A set of n items loads at one item per cycle; in_ready is low from the
// closing item until the final sorted item is taken.
// Each merge pass reads and writes each element (S_RD, S_WR) and handles each
// run pair (S_SETUP, S_NEXT), over ceil(log2 n) passes, through one comparator
// and the registered bank reads. Draining reads each element (S_OUT_RD) and
// holds it until out_ready (S_OUT). Reset is asynchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_merge_sorter_core_defines.svh"
module stable_merge_sorter_core import sms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [FIELD_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] sorted_value,
	output logic                      sorted_last
);
	typedef enum logic [2:0] {
		S_LOAD,
		S_SETUP,
		S_RD,
		S_WR,
		S_NEXT,
		S_OUT_RD,
		S_OUT
	} state_t;

	state_t st_q;
	cnt_t   cnt_q;
	cnt_t   n_q;
	cnt_t   width_q;
	cnt_t   lo_q;
	cnt_t   mid_q;
	cnt_t   hi_q;
	cnt_t   a_q;
	cnt_t   b_q;
	cnt_t   k_q;
	logic   src_q;

	ram_wr_t wr0;
	ram_wr_t wr1;
	ram_rd_t rd;
	data_t   rd0_a;
	data_t   rd0_b;
	data_t   rd1_a;
	data_t   rd1_b;
	data_t   da;
	data_t   db;
	data_t   merge_data;
	logic    le;
	logic    take_a;
	logic    in_acc;
	logic    out_acc;
	logic    load_close;
	logic    in_out;

	logic [SUM_W-1:0] n_ext;
	logic [SUM_W-1:0] mid_sum;
	logic [SUM_W-1:0] hi_sum;
	logic [SUM_W-1:0] wid2;
	cnt_t             mid_clip;
	cnt_t             hi_clip;

	sms_ram u_bank0 (
		.clk     (clk),
		.wr      (wr0),
		.rd      (rd),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	sms_ram u_bank1 (
		.clk     (clk),
		.wr      (wr1),
		.rd      (rd),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

	sms_cmp u_cmp (
		.lhs (da),
		.rhs (db),
		.le  (le)
	);

	assign in_ready   = (st_q == S_LOAD);
	assign out_valid  = (st_q == S_OUT);
	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign load_close = last || (cnt_q == cnt_t'(DEPTH - 1));
	assign in_out     = (st_q == S_OUT_RD) || (st_q == S_OUT);

	assign da = src_q ? rd1_a : rd0_a;
	assign db = src_q ? rd1_b : rd0_b;

	assign take_a     = (a_q < mid_q) && (!(b_q < hi_q) || le);
	assign merge_data = take_a ? da : db;

	assign n_ext    = SUM_W'(n_q);
	assign mid_sum  = SUM_W'(lo_q) + SUM_W'(width_q);
	assign wid2     = SUM_W'(width_q) << 1;
	assign hi_sum   = SUM_W'(lo_q) + wid2;
	assign mid_clip = (mid_sum > n_ext) ? n_q : CNT_W'(mid_sum);
	assign hi_clip  = (hi_sum > n_ext) ? n_q : CNT_W'(hi_sum);

	always_comb begin
		rd.addr_a = in_out ? k_q[IDX_W-1:0] : a_q[IDX_W-1:0];
		rd.addr_b = b_q[IDX_W-1:0];

		wr0.en   = (st_q == S_LOAD) ? in_acc : ((st_q == S_WR) && src_q);
		wr0.addr = (st_q == S_LOAD) ? cnt_q[IDX_W-1:0] : k_q[IDX_W-1:0];
		wr0.data = (st_q == S_LOAD) ? data_t'(value) : merge_data;

		wr1.en   = (st_q == S_WR) && !src_q;
		wr1.addr = k_q[IDX_W-1:0];
		wr1.data = merge_data;
	end

	assign sorted_value = FIELD_W'(da);
	assign sorted_last  = ((k_q + cnt_t'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			width_q <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			src_q   <= 1'b0;
		end else begin
			unique case (st_q)
				S_LOAD: begin
					src_q <= 1'b0;
					if (in_acc) begin
						cnt_q <= cnt_q + cnt_t'(1);
						if (load_close) begin
							n_q     <= cnt_q + cnt_t'(1);
							width_q <= cnt_t'(1);
							lo_q    <= '0;
							k_q     <= '0;
							if (cnt_q == '0) begin
								st_q <= S_OUT_RD;
							end else begin
								st_q <= S_SETUP;
							end
						end
					end
				end
				S_SETUP: begin
					a_q   <= lo_q;
					k_q   <= lo_q;
					mid_q <= mid_clip;
					b_q   <= mid_clip;
					hi_q  <= hi_clip;
					st_q  <= S_RD;
				end
				S_RD: begin
					st_q <= S_WR;
				end
				S_WR: begin
					k_q <= k_q + cnt_t'(1);
					if (take_a) begin
						a_q <= a_q + cnt_t'(1);
					end else begin
						b_q <= b_q + cnt_t'(1);
					end
					if ((k_q + cnt_t'(1)) == hi_q) begin
						st_q <= S_NEXT;
					end else begin
						st_q <= S_RD;
					end
				end
				S_NEXT: begin
					if (hi_sum >= n_ext) begin
						src_q   <= !src_q;
						width_q <= CNT_W'(wid2);
						lo_q    <= '0;
						if (wid2 >= n_ext) begin
							k_q  <= '0;
							st_q <= S_OUT_RD;
						end else begin
							st_q <= S_SETUP;
						end
					end else begin
						lo_q <= CNT_W'(hi_sum);
						st_q <= S_SETUP;
					end
				end
				S_OUT_RD: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (sorted_last) begin
							cnt_q <= '0;
							st_q  <= S_LOAD;
						end else begin
							k_q  <= k_q + cnt_t'(1);
							st_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					st_q <= S_LOAD;
				end
			endcase
		end
	end

	`SMS_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
	`SMS_ASSERT_NOW(a_cnt_range, st_q == S_LOAD, cnt_q < cnt_t'(DEPTH))
	`SMS_ASSERT_NOW(a_merge_live, st_q == S_WR, (k_q < hi_q) && ((a_q < mid_q) || (b_q < hi_q)))
	`SMS_ASSERT_NEXT(a_back_to_load, out_valid && out_ready && sorted_last, in_ready)
endmodule
`default_nettype wire

[rtl/core/sms_ram.sv]
// Element bank: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module sms_ram import sms_pkg::*; (
	input  logic    clk,
	input  ram_wr_t wr,
	input  ram_rd_t rd,
	output data_t   rdata_a,
	output data_t   rdata_b
);
	data_t mem_q [DEPTH];
	data_t rdata_a_q;
	data_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_a_q <= mem_q[rd.addr_a];
		rdata_b_q <= mem_q[rd.addr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule
`default_nettype wire

[rtl/core/sms_cmp.sv]
// Shared signed less-or-equal comparator
`timescale 1ns / 1ps
`default_nettype none
module sms_cmp import sms_pkg::*; (
	input  data_t lhs,
	input  data_t rhs,
	output logic  le
);
	data_t lhs_key;
	data_t rhs_key;

	assign lhs_key = lhs ^ SIGN_MASK;
	assign rhs_key = rhs ^ SIGN_MASK;
	assign le      = (lhs_key <= rhs_key);
endmodule
`default_nettype wire
